/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/stbr_pkg.sv */
package stbr_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 16;
  localparam int STAT_W  = 2;
  localparam int RSLOT_W = 4;
  localparam int PROD_W  = 2 * CNT_W;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic             used;
    logic [CNT_W-1:0] wins;
    logic [CNT_W-1:0] games;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic set;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic mul;
    logic cmp;
  } ratio_ctrl_t;

endpackage

/* src/stbr_cell.sv */
// One table slot; shifts toward the head during a scan.
module stbr_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  stbr_pkg::cell_ctrl_t ctrl,
  input  stbr_pkg::slot_t     prev_i,
  input  stbr_pkg::slot_t     wr_i,
  output stbr_pkg::slot_t     cell_o
);

  logic                       used_r, used_nxt;
  logic [stbr_pkg::CNT_W-1:0] wins_r, wins_nxt;
  logic [stbr_pkg::CNT_W-1:0] matches_r, matches_nxt;

  always_comb begin
    used_nxt    = used_r;
    wins_nxt    = wins_r;
    matches_nxt = matches_r;
    if (ctrl.shift) begin
      used_nxt    = prev_i.used;
      wins_nxt    = prev_i.wins;
      matches_nxt = prev_i.games;
    end else if (ctrl.set) begin
      used_nxt    = wr_i.used;
      wins_nxt    = wr_i.wins;
      matches_nxt = wr_i.games;
    end else if (ctrl.clr) begin
      used_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wins_r    <= wins_nxt;
    matches_r <= matches_nxt;
  end

  assign cell_o = '{used: used_r, wins: wins_r, games: matches_r};

endmodule

/* src/stbr_ratio.sv */
// Shared cross-multiply compare: products are registered, then compared in the next cycle.
module stbr_ratio #(
  parameter int SLOTS = stbr_pkg::SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stbr_pkg::ratio_ctrl_t  ctrl,
  input  stbr_pkg::slot_t        head_i,
  input  logic [$clog2(SLOTS)-1:0] head_idx_i,
  output logic [$clog2(SLOTS)-1:0] best_idx_o
);

  localparam int IW = $clog2(SLOTS);

  logic [stbr_pkg::CNT_W-1:0]  best_w_r, best_w_nxt;
  logic [stbr_pkg::CNT_W-1:0]  best_m_r, best_m_nxt;
  logic [IW-1:0]               best_idx_r, best_idx_nxt;
  logic [stbr_pkg::PROD_W-1:0] prod_a_r, prod_a_nxt;
  logic [stbr_pkg::PROD_W-1:0] prod_b_r, prod_b_nxt;
  logic                        used_r, used_nxt;

  always_comb begin
    best_w_nxt   = best_w_r;
    best_m_nxt   = best_m_r;
    best_idx_nxt = best_idx_r;
    prod_a_nxt   = prod_a_r;
    prod_b_nxt   = prod_b_r;
    used_nxt     = used_r;
    if (ctrl.init) begin
      best_w_nxt   = '0;
      best_m_nxt   = stbr_pkg::CNT_W'(1);
      best_idx_nxt = '0;
    end else if (ctrl.mul) begin
      prod_a_nxt = stbr_pkg::PROD_W'(head_i.wins) * stbr_pkg::PROD_W'(best_m_r);
      prod_b_nxt = stbr_pkg::PROD_W'(best_w_r) * stbr_pkg::PROD_W'(head_i.games);
      used_nxt   = head_i.used;
    end else if (ctrl.cmp) begin
      // head is still the same slot; it moves on at the end of this cycle
      if (used_r && (prod_a_r > prod_b_r)) begin
        best_w_nxt   = head_i.wins;
        best_m_nxt   = head_i.games;
        best_idx_nxt = head_idx_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_idx_r <= '0;
      used_r     <= 1'b0;
    end else begin
      best_idx_r <= best_idx_nxt;
      used_r     <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_w_r <= best_w_nxt;
    best_m_r <= best_m_nxt;
    prod_a_r <= prod_a_nxt;
    prod_b_r <= prod_b_nxt;
  end

  assign best_idx_o = best_idx_r;

endmodule

/* src/slot_table_best_ratio_core.sv */
// Add, remove and the unused command: the result strobe is registered at the accepting edge; busy stays low.
// Query: busy through the MUL/CMP scan and ST_DONE, strobe in the cycle in which busy drops;
//   the ring of slot cells rotates one slot per MUL/CMP pair past one shared multiply unit.
// The receiver cannot stall: out_valid is a single-cycle strobe.
// Reset (rst_n low, synchronous) empties the table and idles the controller;
//   stored wins/matches are not cleared.
`include "assert_macros.svh"

module slot_table_best_ratio_core #(
  parameter int SLOTS = stbr_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [stbr_pkg::CMD_W-1:0]    in_command,
  input  logic [stbr_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [stbr_pkg::CNT_W-1:0]    in_win_count,
  input  logic [stbr_pkg::CNT_W-1:0]    in_match_count,
  output logic                          out_valid,
  output logic [stbr_pkg::STAT_W-1:0]   out_status,
  output logic [stbr_pkg::RSLOT_W-1:0]  out_result_slot
);

  localparam int IW = $clog2(SLOTS);

  // Controller states. MUL/CMP alternate once per slot during a query scan.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 cnt_r, cnt_nxt;        // slot at the ring head
  logic                          out_valid_r, out_valid_nxt;
  logic [stbr_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [stbr_pkg::RSLOT_W-1:0]  out_result_slot_r, out_result_slot_nxt;

  stbr_pkg::slot_t               cells [SLOTS];
  stbr_pkg::cell_ctrl_t          cctl [SLOTS];
  stbr_pkg::slot_t               wr_data;
  stbr_pkg::ratio_ctrl_t         rctl;
  logic [SLOTS-1:0]              set_vec, clr_vec;
  logic                          shift_en;

  logic [IW-1:0]                 free_idx;
  logic                          free_any;
  logic [IW-1:0]                 best_idx;
  logic [IW+stbr_pkg::RSLOT_W-1:0] free_ext, best_ext;
  logic                          in_range;
  logic                          scan_last;

  assign wr_data = '{used: 1'b1, wins: in_win_count, games: in_match_count};

  // Ring of slot cells. Cell i takes from cell i+1, the last takes from cell 0,
  // so after SLOTS shifts the table is back in place.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cctl[i] = '{shift: shift_en, set: set_vec[i], clr: clr_vec[i]};
    stbr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (cctl[i]),
      .prev_i (cells[(i + 1) % SLOTS]),
      .wr_i   (wr_data),
      .cell_o (cells[i])
    );
  end

  stbr_ratio #(.SLOTS(SLOTS)) u_ratio (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (rctl),
    .head_i     (cells[0]),
    .head_idx_i (cnt_r),
    .best_idx_o (best_idx)
  );

  // Lowest free slot; only looked at while idle, when the ring is aligned.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!cells[i].used) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  // Slot numbers wider than the result field keep their low bits.
  assign free_ext  = {{stbr_pkg::RSLOT_W{1'b0}}, free_idx};
  assign best_ext  = {{stbr_pkg::RSLOT_W{1'b0}}, best_idx};
  assign in_range  = ({1'b0, in_slot_index} < (stbr_pkg::IDX_W + 1)'(SLOTS));
  assign scan_last = (cnt_r == IW'(SLOTS - 1));

  always_comb begin
    state_nxt           = state_r;
    cnt_nxt             = cnt_r;
    out_valid_nxt       = 1'b0;
    out_status_nxt      = out_status_r;
    out_result_slot_nxt = out_result_slot_r;
    set_vec             = '0;
    clr_vec             = '0;
    shift_en            = 1'b0;
    rctl                = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            stbr_pkg::CMD_ADD: begin
              out_valid_nxt = 1'b1;
              if (free_any) begin
                set_vec[free_idx]   = 1'b1;
                out_status_nxt      = stbr_pkg::STAT_OK;
                out_result_slot_nxt = free_ext[stbr_pkg::RSLOT_W-1:0];
              end else begin
                out_status_nxt      = stbr_pkg::STAT_FULL;
                out_result_slot_nxt = '0;
              end
            end
            stbr_pkg::CMD_REMOVE: begin
              out_valid_nxt       = 1'b1;
              out_result_slot_nxt = '0;
              if (in_range) begin
                clr_vec[in_slot_index[IW-1:0]] = 1'b1;
                out_status_nxt = stbr_pkg::STAT_OK;
              end else begin
                out_status_nxt = stbr_pkg::STAT_RANGE;
              end
            end
            stbr_pkg::CMD_QUERY: begin
              rctl.init = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_MUL;
            end
            default: begin
              // unused command: no-op, ok with slot 0
              out_valid_nxt       = 1'b1;
              out_status_nxt      = stbr_pkg::STAT_OK;
              out_result_slot_nxt = '0;
            end
          endcase
        end
      end
      ST_MUL: begin
        rctl.mul  = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        rctl.cmp = 1'b1;
        shift_en = 1'b1;
        if (scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        out_valid_nxt       = 1'b1;
        out_status_nxt      = stbr_pkg::STAT_OK;
        out_result_slot_nxt = best_ext[stbr_pkg::RSLOT_W-1:0];
        state_nxt           = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r      <= out_status_nxt;
    out_result_slot_r <= out_result_slot_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_result_slot_r;

  // Add/remove/no-op answer on the next cycle.
  `ASSERT_NXT(a_direct_resp, clk, rst_n, start && !busy && (in_command != stbr_pkg::CMD_QUERY), out_valid)
  // A query never answers on the next cycle; it starts a scan.
  `ASSERT_NXT(a_query_scan, clk, rst_n, start && !busy && (in_command == stbr_pkg::CMD_QUERY), busy && !out_valid)
  // Last compare of the scan leads to ST_DONE and then to the query answer.
  `ASSERT_NXT(a_scan_end, clk, rst_n, (state_r == ST_CMP) && scan_last, (state_r == ST_DONE) ##1 out_valid)
  // Errors always report slot 0.
  `ASSERT_IMP(a_err_slot, clk, rst_n, out_valid && (out_status != stbr_pkg::STAT_OK), out_result_slot == '0)

endmodule
